// File: rtl/jse_pkg.sv
package jse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned IdxW   = 3;

  localparam logic [CountW-1:0] CapReset = 16'd256;

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChLowA  = 8'h61;
  localparam logic [ByteW-1:0] ChLowN  = 8'h6e;
  localparam logic [ByteW-1:0] ChLowR  = 8'h72;
  localparam logic [ByteW-1:0] ChLowT  = 8'h74;
  localparam logic [ByteW-1:0] ChLowU  = 8'h75;

  // Register indexes
  localparam logic RegOutCapacity = 1'b0;

  // What the back end has to emit for one queued item
  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,  // zero terminator, marked last
    KIND_PLAIN = 2'd1,  // byte as is
    KIND_ESC2  = 2'd2,  // backslash, then byte
    KIND_UNI   = 2'd3   // backslash u 0 0 hex hex
  } jse_kind_t;

  typedef struct packed {
    jse_kind_t        kind;
    logic [ByteW-1:0] data;
  } jse_entry_t;

  function automatic logic [IdxW-1:0] kind_len(input jse_kind_t kind);
    logic [IdxW-1:0] len;
    case (kind)
      KIND_ESC2: len = 3'd2;
      KIND_UNI:  len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v);
    logic [ByteW-1:0] ch;
    if (v < 4'd10) begin
      ch = ChZero + {4'b0, v};
    end else begin
      ch = ChLowA + {4'b0, v - 4'd10};
    end
    return ch;
  endfunction

endpackage

// File: rtl/jse_front.sv
module jse_front
  import jse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CountW-1:0] out_capacity,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_byte,
  output logic              push,
  output jse_entry_t        push_entry,
  input  logic              queue_full
);

  logic [CountW-1:0] emitted_count;
  logic              stopped;

  logic              accept;
  logic              is_ctl;
  logic [CountW:0]   need_sum;
  logic              fits;
  logic [IdxW-1:0]   n_out;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // control bytes other than tab, newline and carriage return need \u00xx
  assign is_ctl = (in_byte < ChSpace) && (in_byte != ChLf) && (in_byte != ChCr)
                  && (in_byte != ChTab);

  assign need_sum = {1'b0, emitted_count} + (is_ctl ? 17'd6 : 17'd2);
  assign fits     = need_sum < {1'b0, out_capacity};

  always_comb begin
    push_entry.data = in_byte;
    if (in_byte == ChNul) begin
      push_entry.kind = KIND_TERM;
    end else if (in_byte == ChQuote || in_byte == ChBslash) begin
      push_entry.kind = KIND_ESC2;
    end else if (in_byte == ChLf) begin
      push_entry.kind = KIND_ESC2;
      push_entry.data = ChLowN;
    end else if (in_byte == ChCr) begin
      push_entry.kind = KIND_ESC2;
      push_entry.data = ChLowR;
    end else if (in_byte == ChTab) begin
      push_entry.kind = KIND_ESC2;
      push_entry.data = ChLowT;
    end else if (is_ctl) begin
      push_entry.kind = KIND_UNI;
    end else begin
      push_entry.kind = KIND_PLAIN;
    end
  end

  assign n_out = kind_len(push_entry.kind);
  assign push  = accept && ((in_byte == ChNul) || (!stopped && fits));

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
      stopped       <= 1'b0;
    end else if (accept) begin
      if (in_byte == ChNul) begin
        emitted_count <= '0;
        stopped       <= 1'b0;
      end else if (!stopped) begin
        if (fits) begin
          emitted_count <= emitted_count + {{(CountW-IdxW){1'b0}}, n_out};
        end else begin
          stopped <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/jse_queue.sv
module jse_queue
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  jse_entry_t din,
  input  logic       pop,
  output jse_entry_t dout,
  output logic       full,
  output logic       empty
);

  jse_entry_t       slots [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  assign full  = count == QCntW'(QDepth);
  assign empty = count == '0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jse_back.sv
module jse_back
  import jse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  jse_entry_t       head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last
);

  logic [IdxW-1:0]  idx;
  logic             load;
  logic             at_end;
  logic [ByteW-1:0] sel_byte;

  assign load   = head_valid && (!out_valid || out_ready);
  assign at_end = idx == kind_len(head.kind) - 3'd1;
  assign pop    = load && at_end;

  always_comb begin
    case (head.kind)
      KIND_TERM:  sel_byte = ChNul;
      KIND_PLAIN: sel_byte = head.data;
      KIND_ESC2:  sel_byte = (idx == 3'd0) ? ChBslash : head.data;
      KIND_UNI: begin
        case (idx)
          3'd0:    sel_byte = ChBslash;
          3'd1:    sel_byte = ChLowU;
          3'd4:    sel_byte = hex_char(head.data[7:4]);
          3'd5:    sel_byte = hex_char(head.data[3:0]);
          default: sel_byte = ChZero;
        endcase
      end
      default:    sel_byte = ChNul;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_end ? '0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= head.kind == KIND_TERM;
    end
  end

endmodule

// File: rtl/json_string_escaper.sv
// JSON string escaper. Bytes of a string enter on s_t* one per item; the
// escaped form leaves on m_t*, one byte per item. Quote and backslash get a
// backslash prefix, newline/return/tab become \n \r \t, other bytes below
// 0x20 become \u00xx (lower-case hex), everything else passes through. A
// zero byte emits a zero marked with m_tlast and starts a new string. The
// out_capacity register (address 0, reset 256) bounds the escaped length
// including the terminator; the first byte that does not fit, and every
// byte after it up to the zero, is dropped. Rate: the input takes one byte
// per cycle while the 4-entry queue between classifier and emitter has
// room; the emitter drives the single output register with one byte per
// cycle while m_tready is high, so an escape costs 2 or 6 output bytes and
// long runs of escapes throttle the input to the output rate. A byte goes
// through the queue, then the output register; dropped bytes emit nothing.
module json_string_escaper
  import jse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast
);

  logic [CountW-1:0] out_capacity;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  jse_entry_t        push_entry;
  jse_entry_t        head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegOutCapacity) ? {16'b0, out_capacity} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CapReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == RegOutCapacity) begin
      out_capacity <= pwdata[CountW-1:0];
    end
  end

  jse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .out_capacity (out_capacity),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (q_full)
  );

  jse_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_entry),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// File: rtl/jse_checker.sv
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // escaped text never holds a zero byte: only the terminator is zero
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata == 8'h00) == m_tlast))
    else $error("zero byte and last marker disagree");

  // a terminator is never directly followed by an unmarked zero:
  // after last is taken, the next item cannot repeat a zero unless last
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> (m_tlast || m_tdata != 8'h00))
    else $error("unmarked zero after terminator");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: dv/json_escape_check_pkg.sv
package json_escape_check_pkg;

  import jse_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_out_t;

  // Predicts the escaped byte stream and holds the bytes still owed by the dut.
  class escaped_stream_checker;

    esc_out_t    owed[$];
    logic [15:0] capacity;
    logic [15:0] used;
    bit          halted;

    function new();
      capacity = CapReset;
      used     = '0;
      halted   = 1'b0;
    endfunction

    function void set_capacity(input logic [15:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void push(input logic [7:0] data, input logic last);
      esc_out_t e;
      e.data = data;
      e.last = last;
      owed.push_back(e);
      if (!last) used = used + 16'd1;
    endfunction

    function logic [7:0] nibble_char(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 4'd10) ch = 8'h30 + 8'(v);
      else ch = 8'h61 + 8'(v) - 8'd10;
      return ch;
    endfunction

    // Note one accepted input item.
    function void take_input(input logic [7:0] c);
      int unsigned need;
      need = 2;
      if (c == ChNul) begin
        push(ChNul, 1'b1);
        used   = '0;
        halted = 1'b0;
        return;
      end
      if (halted) return;
      if (c < ChSpace && c != ChLf && c != ChCr && c != ChTab) need = 6;
      if (32'(used) + need >= 32'(capacity)) begin
        halted = 1'b1;
        return;
      end
      if (c == ChQuote || c == ChBslash) begin
        push(ChBslash, 1'b0);
        push(c, 1'b0);
      end else if (c == ChLf) begin
        push(ChBslash, 1'b0);
        push(ChLowN, 1'b0);
      end else if (c == ChCr) begin
        push(ChBslash, 1'b0);
        push(ChLowR, 1'b0);
      end else if (c == ChTab) begin
        push(ChBslash, 1'b0);
        push(ChLowT, 1'b0);
      end else if (c < ChSpace) begin
        push(ChBslash, 1'b0);
        push(ChLowU, 1'b0);
        push(ChZero, 1'b0);
        push(ChZero, 1'b0);
        push(nibble_char(c[7:4]), 1'b0);
        push(nibble_char(c[3:0]), 1'b0);
      end else begin
        push(c, 1'b0);
      end
    endfunction

    // Compare one output item with the oldest owed byte.
    function bit check_output(input logic [7:0] data, input logic last, output string why);
      esc_out_t want;
      why = "";
      if (owed.size() == 0) begin
        why = $sformatf("unexpected output byte %02h last %b", data, last);
        return 1'b0;
      end
      want = owed.pop_front();
      if (data !== want.data || last !== want.last) begin
        why = $sformatf("out_byte %02h (want %02h), last %b (want %b)",
                        data, want.data, last, want.last);
        return 1'b0;
      end
      return 1'b1;
    endfunction

  endclass

endpackage

// File: dv/tb_json_string_escaper.sv
module tb_json_string_escaper;

  timeunit 1ns;
  timeprecision 1ps;

  import jse_pkg::*;
  import json_escape_check_pkg::*;

  localparam int unsigned SinkHoldCycles = 200;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;

  escaped_stream_checker sb = new();

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          sink_hold  = 1'b0;

  json_string_escaper dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** json_string_escaper: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string why);
    mismatches++;
    if (mismatches <= 20) $display("[%0t] mismatch: %s", $realtime, why);
  endtask

  function automatic int unsigned tx_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned rx_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_text_byte();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 45) b = 8'($urandom_range(8'h20, 8'h7f));
    else if (r < 55) b = $urandom_range(0, 1) ? ChQuote : ChBslash;
    else if (r < 65) begin
      case ($urandom_range(0, 2))
        0:       b = ChLf;
        1:       b = ChCr;
        default: b = ChTab;
      endcase
    end else if (r < 80) b = 8'($urandom_range(8'h01, 8'h1f));
    else b = 8'($urandom_range(8'h80, 8'hff));
    return b;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        hold_left = SinkHoldCycles;
        sink_hold = 1'b0;
      end else if (hold_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        hold_left = rx_gap();
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_out
    string why;
    if (!rst && m_tvalid && m_tready) begin
      if (!sb.check_output(m_tdata, m_tlast, why)) report_mismatch(why);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_input(b);
    bytes_sent++;
    gap = tx_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain everything owed; dropped bytes leave nothing owed, so the wait goes on after that.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegOutCapacity) << 2;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic run_phase(input logic [15:0] cap, input int unsigned quota,
                           input bit tx_idle, input bit rx_idle,
                           input bit squeeze, input bit drain_mid);
    int unsigned start;
    int unsigned len;
    int unsigned longest;
    int unsigned r;
    bit          drained;
    settle();
    write_capacity(cap);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    if (squeeze) sink_hold = 1'b1;
    start   = bytes_sent;
    drained = 1'b0;
    longest = (cap >= 16'd200) ? 180 : 40;
    while (bytes_sent - start < quota) begin
      if (drain_mid && !drained && bytes_sent - start >= quota / 2) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 88) len = $urandom_range(1, 20);
      else len = $urandom_range(21, longest);
      // keep the phase close to its quota
      if (len > quota - (bytes_sent - start)) len = quota - (bytes_sent - start);
      repeat (len) send_byte(rand_text_byte());
      // now and then the terminator is left out and strings run together
      if ($urandom_range(0, 19) != 0) send_byte(ChNul);
    end
  endtask

  initial begin : main
    logic [7:0] corners[$];
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every escape class and the byte extremes at the reset capacity
    corners = '{ChNul, 8'h01, 8'h1f, 8'h1a, 8'h0b, ChTab, ChLf, ChCr, ChQuote,
                ChBslash, ChSpace, 8'h7f, 8'h80, 8'hff, ChNul};
    foreach (corners[i]) send_byte(corners[i]);

    // capacity of one: nothing fits, the terminator still comes out
    settle();
    write_capacity(16'd1);
    send_byte(8'h41);
    send_byte(ChNul);

    // second byte overflows, later bytes dropped until the zero
    settle();
    write_capacity(16'd3);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(ChNul);

    // \u escape that just fits, then one that just misses
    settle();
    write_capacity(16'd7);
    send_byte(8'h01);
    send_byte(ChNul);
    settle();
    write_capacity(16'd6);
    send_byte(8'h01);
    send_byte(8'h78);
    send_byte(ChNul);

    run_phase(16'd256,   60, 1'b0, 1'b0, 1'b1, 1'b0);
    run_phase(16'd12,    45, 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase(16'd3,     30, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(16'd65535, 60, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd7,     40, 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(16'd1,     25, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd25,    50, 1'b0, 1'b0, 1'b1, 1'b1);
    run_phase(16'd2,     20, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd40,    50, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd256,   70, 1'b1, 1'b1, 1'b0, 1'b1);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && sb.pending() == 0) begin
      $display("** json_string_escaper: PASSED **");
    end else begin
      $display("** json_string_escaper: FAILED **");
    end
    $finish;
  end

endmodule
